>>> design/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int TRIG_STAGES_DEF   = 16;

	localparam logic [15:0] NEG_FOLD   = 16'd19456;
	localparam logic [15:0] QUAD_UNITS = 16'd11520;
	localparam logic [13:0] RECIP45    = 14'd11651;
	localparam int          RECIP_SH   = 19;

	localparam longint unsigned PI4_Q40 = 64'd863554413089;
	localparam longint unsigned ZRND    = 64'd2949120;
	localparam longint unsigned ZDIV    = 64'd5898240;
	localparam logic [23:0]     ZCMP    = 24'd5898240;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef logic [22:0] ztab_t [0:44];

	function automatic logic signed [31:0] atan_q30(input int i);
		logic signed [31:0] v;
		case (i)
			0:       v = 32'sd843314857;
			1:       v = 32'sd497837829;
			2:       v = 32'sd263043837;
			3:       v = 32'sd133525159;
			4:       v = 32'sd67021687;
			5:       v = 32'sd33543516;
			6:       v = 32'sd16775851;
			7:       v = 32'sd8388437;
			8:       v = 32'sd4194283;
			9:       v = 32'sd2097149;
			31:      v = 32'sd1;
			default: v = 32'sd1 <<< (30 - i);
		endcase
		return v;
	endfunction

	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned rq;
		longint unsigned rr;
		int b;
		rq = 0;
		rr = 0;
		for (b = 63; b >= 0; b--) begin
			rr = (rr << 1) | longint'(num[b]);
			if (rr >= den) begin
				rr = rr - den;
				rq[b] = 1'b1;
			end
		end
		return rq;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned val);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = val;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned cordic_k(input int n);
		longint unsigned gain;
		longint unsigned sq;
		int i;
		gain = 64'd1 << 60;
		for (i = 0; i < n; i++)
			gain = gain + (gain >> (2 * i));
		sq = isqrt64(gain);
		return udiv64((64'd1 << 60) + (sq >> 1), sq);
	endfunction

	function automatic ztab_t mk_bq();
		ztab_t t;
		longint unsigned b;
		int r;
		for (r = 0; r < 45; r++) begin
			b = longint'(r) * PI4_Q40 + ZRND;
			t[r] = 23'(b / ZDIV);
		end
		return t;
	endfunction

	function automatic ztab_t mk_br();
		ztab_t t;
		longint unsigned b;
		int r;
		for (r = 0; r < 45; r++) begin
			b = longint'(r) * PI4_Q40 + ZRND;
			t[r] = 23'(b % ZDIV);
		end
		return t;
	endfunction

	localparam ztab_t BQ_TAB = mk_bq();
	localparam ztab_t BR_TAB = mk_br();

endpackage

`default_nettype wire

>>> design/euler_to_quaternion_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle while the output is not stalled; the CORDIC rotation is one register stage per step.
// A stall on a valid output freezes the whole pipeline and stalls the input.
// Reset clears the stage valid bits only; no item survives reset.

module euler_to_quaternion_core #(
	parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF,
	parameter int TRIG_STAGES   = e2q_pkg::TRIG_STAGES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            angles_valid,
	output logic                 angles_stall,
	input  wire e2q_pkg::angles_t angles,
	output logic                 quat_valid,
	input  wire logic            quat_stall,
	output e2q_pkg::quat_t       quat
);

	localparam int N   = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;
	localparam int LAT = N + 10;
	localparam int SH  = 60 - OUT_FRAC_BITS;
	localparam logic signed [63:0] RND     = 64'sd1 <<< (SH - 1);
	localparam logic signed [63:0] ONE     = 64'sd1 <<< OUT_FRAC_BITS;
	localparam logic signed [63:0] ROUND30 = 64'sd1 <<< 29;

	logic en;
	logic [LAT-1:0] vld_q;

	assign en           = !(vld_q[LAT-1] && quat_stall);
	assign angles_stall = !en;
	assign quat_valid   = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], angles_valid};
		end
	end

	logic signed [31:0] cp, sp, cy, sy, cz, sz;

	e2q_trig #(.STAGES(N)) u_pitch (
		.clk(clk), .en(en), .angle(angles.pitch_angle), .cos_val(cp), .sin_val(sp)
	);
	e2q_trig #(.STAGES(N)) u_yaw (
		.clk(clk), .en(en), .angle(angles.yaw_angle), .cos_val(cy), .sin_val(sy)
	);
	e2q_trig #(.STAGES(N)) u_roll (
		.clk(clk), .en(en), .angle(angles.roll_angle), .cos_val(cz), .sin_val(sz)
	);

	logic signed [63:0] pw_s1, px_s1, py_s1, pz_s1;
	logic signed [31:0] cp_s1, sp_s1, cp_s2, sp_s2;
	logic signed [31:0] w1_s2, x1_s2, y1_s2, z1_s2;
	logic signed [63:0] ww_s3, xs_s3, ws_s3, xc_s3, yc_s3, zs_s3, zc_s3, ys_s3;
	logic signed [63:0] sw_s4, sx_s4, sy_s4, sz_s4;

	function automatic logic signed [15:0] finish(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + RND) >>> SH;
		if (r > ONE)
			r = ONE;
		if (r < -ONE)
			r = -ONE;
		if (r > 64'sd32767)
			r = 64'sd32767;
		if (r < -64'sd32768)
			r = -64'sd32768;
		return r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s1 <= 64'(cz) * 64'(cy);
			px_s1 <= -(64'(sz) * 64'(sy));
			py_s1 <= 64'(cz) * 64'(sy);
			pz_s1 <= 64'(sz) * 64'(cy);
			cp_s1 <= cp;
			sp_s1 <= sp;

			w1_s2 <= 32'((pw_s1 + ROUND30) >>> 30);
			x1_s2 <= 32'((px_s1 + ROUND30) >>> 30);
			y1_s2 <= 32'((py_s1 + ROUND30) >>> 30);
			z1_s2 <= 32'((pz_s1 + ROUND30) >>> 30);
			cp_s2 <= cp_s1;
			sp_s2 <= sp_s1;

			ww_s3 <= 64'(w1_s2) * 64'(cp_s2);
			xs_s3 <= 64'(x1_s2) * 64'(sp_s2);
			ws_s3 <= 64'(w1_s2) * 64'(sp_s2);
			xc_s3 <= 64'(x1_s2) * 64'(cp_s2);
			yc_s3 <= 64'(y1_s2) * 64'(cp_s2);
			zs_s3 <= 64'(z1_s2) * 64'(sp_s2);
			zc_s3 <= 64'(z1_s2) * 64'(cp_s2);
			ys_s3 <= 64'(y1_s2) * 64'(sp_s2);

			sw_s4 <= ww_s3 - xs_s3;
			sx_s4 <= ws_s3 + xc_s3;
			sy_s4 <= yc_s3 + zs_s3;
			sz_s4 <= zc_s3 - ys_s3;

			quat.quat_w <= finish(sw_s4);
			quat.quat_x <= finish(sx_s4);
			quat.quat_y <= finish(sy_s4);
			quat.quat_z <= finish(sz_s4);
		end
	end

endmodule

`default_nettype wire

>>> design/e2q_trig.sv
`timescale 1ns / 1ps
`default_nettype none

module e2q_trig #(
	parameter int STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [15:0]        angle,
	output logic signed [31:0]      cos_val,
	output logic signed [31:0]      sin_val
);

	localparam int N = (STAGES > 32) ? 32 : STAGES;
	localparam logic signed [31:0] K = 32'(e2q_pkg::cordic_k(N));

	logic [15:0] a;
	logic [1:0]  quad_d;
	logic [13:0] rem_d;

	always_comb begin
		a = angle[15] ? (angle - e2q_pkg::NEG_FOLD) : angle;
		if (a >= 3 * e2q_pkg::QUAD_UNITS) begin
			quad_d = 2'd3;
			rem_d  = 14'(a - 3 * e2q_pkg::QUAD_UNITS);
		end else if (a >= 2 * e2q_pkg::QUAD_UNITS) begin
			quad_d = 2'd2;
			rem_d  = 14'(a - 2 * e2q_pkg::QUAD_UNITS);
		end else if (a >= e2q_pkg::QUAD_UNITS) begin
			quad_d = 2'd1;
			rem_d  = 14'(a - e2q_pkg::QUAD_UNITS);
		end else begin
			quad_d = 2'd0;
			rem_d  = a[13:0];
		end
	end

	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4;
	logic [13:0] rem_s1;
	logic [7:0]  qd_s2;
	logic [5:0]  rd_s2;
	logic [47:0] prod_s3;
	logic [22:0] bq_s3, br_s3;
	logic signed [31:0] z_s4;

	logic [27:0] recip_p;
	logic [7:0]  qd;
	logic [13:0] rfull;
	logic [23:0] frac_sum;

	always_comb begin
		recip_p  = 28'(rem_s1) * 28'(e2q_pkg::RECIP45);
		qd       = recip_p[e2q_pkg::RECIP_SH +: 8];
		rfull    = rem_s1 - 14'(qd) * 14'd45;
		frac_sum = 24'(prod_s3[16:0]) * 24'd45 + 24'(br_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad_d;
			rem_s1  <= rem_d;
			quad_s2 <= quad_s1;
			qd_s2   <= qd;
			rd_s2   <= rfull[5:0];
			quad_s3 <= quad_s2;
			prod_s3 <= 48'(qd_s2) * 48'(e2q_pkg::PI4_Q40);
			bq_s3   <= e2q_pkg::BQ_TAB[rd_s2];
			br_s3   <= e2q_pkg::BR_TAB[rd_s2];
			quad_s4 <= quad_s3;
			z_s4    <= 32'(prod_s3[47:17]) + 32'(bq_s3)
				+ ((frac_sum >= e2q_pkg::ZCMP) ? 32'sd1 : 32'sd0);
		end
	end

	logic signed [31:0] cx_s [N];
	logic signed [31:0] cy_s [N];
	logic signed [31:0] cz_s [N];
	logic [1:0]         cq_s [N];

	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [31:0] xi, yi, zi;
		logic [1:0]         qi;
		if (i == 0) begin : g_first
			assign xi = K;
			assign yi = 32'sd0;
			assign zi = z_s4;
			assign qi = quad_s4;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign qi = cq_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cq_s[i] <= qi;
				if (!zi[31]) begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - e2q_pkg::atan_q30(i);
				end else begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + e2q_pkg::atan_q30(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (cq_s[N-1])
				2'd0: begin
					cos_val <= cx_s[N-1];
					sin_val <= cy_s[N-1];
				end
				2'd1: begin
					cos_val <= -cy_s[N-1];
					sin_val <= cx_s[N-1];
				end
				2'd2: begin
					cos_val <= -cx_s[N-1];
					sin_val <= -cy_s[N-1];
				end
				default: begin
					cos_val <= cy_s[N-1];
					sin_val <= -cx_s[N-1];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_euler_to_quaternion_core.sv
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;

	localparam int FRAC   = e2q_pkg::OUT_FRAC_BITS_DEF;
	localparam int STAGES = e2q_pkg::TRIG_STAGES_DEF;
	localparam int NSTEP  = STAGES > 32 ? 32 : STAGES;
	localparam int N_RAND = 900;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             angles_valid = 1'b0;
	logic             angles_stall;
	e2q_pkg::angles_t angles = '0;
	logic             quat_valid;
	logic             quat_stall = 1'b1;
	e2q_pkg::quat_t   quat;

	int n_fail = 0;
	int n_in = 0;
	int n_out = 0;

	longint atan_tab [0:31];
	longint pi4_q40;
	longint cordic_gain;

	euler_to_quaternion_core dut (
		.clk(clk), .arst_n(arst_n),
		.angles_valid(angles_valid), .angles_stall(angles_stall), .angles(angles),
		.quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned atan_inv(longint unsigned n);
		longint unsigned p, nn, acc, term, k;
		p = (64'd1 << 62) / n;
		nn = n * n;
		acc = 0;
		k = 0;
		while (p != 0) begin
			term = p / (2 * k + 1);
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
			p = p / nn;
			k++;
		end
		return acc;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned val);
		longint unsigned v, r, b;
		v = val;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic build_trig_constants();
		longint unsigned pi4, g, sq;
		pi4 = 4 * atan_inv(5) - atan_inv(239);
		pi4_q40 = longint'((pi4 + (64'd1 << 21)) >> 22);
		atan_tab[0] = longint'((pi4 + (64'd1 << 31)) >> 32);
		for (int i = 1; i < 32; i++)
			atan_tab[i] = longint'((atan_inv(64'd1 << i) + (64'd1 << 31)) >> 32);
		g = 64'd1 << 60;
		for (int i = 0; i < NSTEP; i++)
			g = g + (g >> (2 * i));
		sq = int_sqrt(g);
		cordic_gain = longint'(((64'd1 << 60) + sq / 2) / sq);
	endtask

	function automatic longint rshift_round(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic void half_angle_trig(logic signed [15:0] raw,
			output longint c, output longint s);
		longint a, quad, rem, z, x, y, dx, dy;
		a = raw;
		if (a < 0)
			a += 46080;
		quad = a / 11520;
		rem = a % 11520;
		z = (rem * pi4_q40 + 5760 * 512) / (5760 * 1024);
		x = cordic_gain;
		y = 0;
		for (int i = 0; i < NSTEP; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic signed [15:0] to_q14(longint q60);
		longint v, one;
		v = rshift_round(q60, 60 - FRAC);
		one = longint'(1) <<< FRAC;
		if (v > one) v = one;
		if (v < -one) v = -one;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	function automatic e2q_pkg::quat_t angles_to_quat(e2q_pkg::angles_t a);
		longint cp, sp, cy, sy, cz, sz, w1, x1, y1, z1;
		e2q_pkg::quat_t q;
		half_angle_trig(a.pitch_angle, cp, sp);
		half_angle_trig(a.yaw_angle, cy, sy);
		half_angle_trig(a.roll_angle, cz, sz);
		w1 = rshift_round(cz * cy, 30);
		x1 = rshift_round(-(sz * sy), 30);
		y1 = rshift_round(cz * sy, 30);
		z1 = rshift_round(sz * cy, 30);
		q.quat_w = to_q14(w1 * cp - x1 * sp);
		q.quat_x = to_q14(w1 * sp + x1 * cp);
		q.quat_y = to_q14(y1 * cp + z1 * sp);
		q.quat_z = to_q14(z1 * cp - y1 * sp);
		return q;
	endfunction

	task automatic report(string what, longint got, longint want);
		n_fail++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	class quat_scoreboard;
		e2q_pkg::quat_t pending_quats[$];

		function void note_angles(e2q_pkg::angles_t a);
			pending_quats.push_back(angles_to_quat(a));
		endfunction

		task check_quat(e2q_pkg::quat_t got);
			e2q_pkg::quat_t want;
			if (pending_quats.size() == 0) begin
				report("unexpected transfer", 0, 0);
				return;
			end
			want = pending_quats.pop_front();
			if (got.quat_w !== want.quat_w) report("quat_w", got.quat_w, want.quat_w);
			if (got.quat_x !== want.quat_x) report("quat_x", got.quat_x, want.quat_x);
			if (got.quat_y !== want.quat_y) report("quat_y", got.quat_y, want.quat_y);
			if (got.quat_z !== want.quat_z) report("quat_z", got.quat_z, want.quat_z);
		endtask
	endclass

	quat_scoreboard sb = new();

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [15:0] rand_angle();
		int r;
		logic signed [15:0] v;
		v = 16'($urandom);
		r = $urandom_range(0, 9);
		case (r)
			0: v = 16'($urandom_range(0, 7) * 5760);
			1: v = 16'(-46080 + 65536 * 0 + $urandom_range(0, 3));
			2: v = 16'($urandom_range(0, 8) * 2880 + $urandom_range(0, 2) - 1);
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_angles(e2q_pkg::angles_t a);
		int g;
		g = pick_gap();
		if (g > 0) begin
			angles_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		angles <= a;
		angles_valid <= 1'b1;
		@(posedge clk);
		while (angles_stall)
			@(posedge clk);
		sb.note_angles(a);
		n_in++;
	endtask

	always @(posedge clk) begin
		if (arst_n && quat_valid && !quat_stall) begin
			sb.check_quat(quat);
			n_out++;
		end
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				quat_stall <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
			g = pick_gap();
			quat_stall <= (g > 0);
			repeat (g > 0 ? g : 1) @(posedge clk);
			quat_stall <= 1'b0;
			@(posedge clk);
		end
	end

	initial begin
		e2q_pkg::angles_t a;
		logic signed [15:0] d [0:11];
		build_trig_constants();
		d = '{16'sh7FFF, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd11520,
			16'sd23040, -16'sd23040, 16'sd11519, 16'sd5760, -16'sd13312, 16'sd17280};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 12; i++) begin
			a.pitch_angle = d[i];
			a.yaw_angle = d[(i + 4) % 12];
			a.roll_angle = d[(i + 8) % 12];
			send_angles(a);
		end
		for (int i = 0; i < 12; i++) begin
			a = '0;
			if (i % 3 == 0) a.pitch_angle = d[i];
			if (i % 3 == 1) a.yaw_angle = d[i];
			if (i % 3 == 2) a.roll_angle = d[i];
			send_angles(a);
		end
		for (int i = 0; i < N_RAND; i++) begin
			a.pitch_angle = rand_angle();
			a.yaw_angle = rand_angle();
			a.roll_angle = rand_angle();
			send_angles(a);
		end
		angles_valid <= 1'b0;
		while (sb.pending_quats.size() != 0)
			@(posedge clk);
		repeat (STAGES + 40) @(posedge clk);
		$display("Converted %0d angle triples (directed extremes, quadrant edges, random)",
			n_in);
		$display("under random input gaps and output stalls; %0d quaternions checked", n_out);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout waiting for transfers");
		$display("Test completed with failures");
		$finish;
	end

endmodule
